// ===== rtl/cuckoo_hash_set_assert.svh =====
// assertion macros for the cuckoo hash set
// no dependencies
`ifndef CUCKOO_HASH_SET_ASSERT_SVH
`define CUCKOO_HASH_SET_ASSERT_SVH

// implication checked every clock outside reset
`define CHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define CHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/chs_pkg.sv =====
// package for the cuckoo hash set: types, constants and a rotate helper for the hashes
// no dependencies
package chs_pkg;

    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = 12;
    localparam int KICK_W = 17;
    localparam logic [KICK_W-1:0] KICKS_RESET = 17'd2048;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_LOOKUP = 2'd1;
    localparam logic [1:0] FUNC_DELETE = 2'd2;
    localparam logic [1:0] FUNC_NOP    = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_PRESENT = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISS    = 2'd3;

    localparam logic [31:0] MM_C1   = 32'hcc9e2d51;
    localparam logic [31:0] MM_C2   = 32'h1b873593;
    localparam logic [31:0] MM_N    = 32'he6546b64;
    localparam logic [31:0] MM_SEED = 32'h12345678;
    localparam logic [31:0] MM_F1   = 32'h85ebca6b;
    localparam logic [31:0] MM_F2   = 32'hc2b2ae35;
    localparam logic [31:0] FNV_OFS = 32'd2166136261;
    localparam logic [31:0] FNV_PRM = 32'd16777619;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
    } t_in_word;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [31:0]      homeless_key;
        logic [CNT_W-1:0] entry_count;
    } t_out_word;

    // classified item handed from front to back
    typedef struct packed {
        logic [1:0]       func;
        logic [31:0]      key;
        logic [IDX_W-1:0] idx1;
        logic [IDX_W-1:0] idx2;
    } t_job;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
        rotl = (x << r) | (x >> (32 - r));
    endfunction

endpackage

// ===== rtl/chs_ram.sv =====
// generic single-port ram with registered read
// no dependencies
module chs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // registered read, returns the old word on a write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

// ===== rtl/chs_hash.sv =====
// pipelined hash unit: murmur3 and fnv-1a slot indices, one word a cycle
// depends on chs_pkg
module chs_hash import chs_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [31:0]      i_key,
    output logic             o_valid,
    output logic [IDX_W-1:0] o_idx1,
    output logic [IDX_W-1:0] o_idx2
);
    logic [5:0]  r_v;
    logic [31:0] r_m0, r_m1, r_m2, r_m3, r_m4, r_m5;
    logic [31:0] r_f0, r_f1, r_f2, r_f3;
    logic [31:0] n_m1, n_m3, n_m4;
    logic [IDX_W-1:0] r_f4, r_f5;
    logic [31:0] r_key_d1, r_key_d2, r_key_d3;

    // valid pipe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v <= '0;
        else          r_v <= {r_v[4:0], i_valid};
    end

    always_comb begin
        n_m1 = rotl(r_m0, 15);
        n_m3 = r_m2 ^ 32'd4;
        n_m3 = n_m3 ^ (n_m3 >> 16);
        n_m4 = r_m3 ^ (r_m3 >> 13);
    end

    // at most one multiply per hash in each stage
    always_ff @(posedge i_clk) begin
        r_m0 <= i_key * MM_C1;
        r_f0 <= (FNV_OFS ^ {24'd0, i_key[7:0]}) * FNV_PRM;
        r_m1 <= n_m1 * MM_C2;
        r_f1 <= (r_f0 ^ {24'd0, r_key_d1[15:8]}) * FNV_PRM;
        r_m2 <= rotl(MM_SEED ^ r_m1, 13) * 32'd5 + MM_N;
        r_f2 <= (r_f1 ^ {24'd0, r_key_d2[23:16]}) * FNV_PRM;
        r_m3 <= n_m3 * MM_F1;
        r_f3 <= (r_f2 ^ {24'd0, r_key_d3[31:24]}) * FNV_PRM;
        r_m4 <= n_m4 * MM_F2;
        r_f4 <= r_f3[IDX_W-1:0];
        r_m5 <= r_m4 ^ (r_m4 >> 16);
        r_f5 <= r_f4;
    end

    // key delay line for the byte-serial fnv
    always_ff @(posedge i_clk) begin
        r_key_d1 <= i_key;
        r_key_d2 <= r_key_d1;
        r_key_d3 <= r_key_d2;
    end

    assign o_valid = r_v[5];
    assign o_idx1  = r_m5[IDX_W-1:0];
    assign o_idx2  = r_f5;
endmodule

// ===== rtl/chs_front.sv =====
// front end: takes input words, hashes the key, queues classified jobs
// depends on chs_pkg, chs_hash
module chs_front import chs_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_word i_data,
    output logic     o_job_valid,
    input  logic     i_job_ready,
    output t_job     o_job
);
    localparam int QD = 8;
    localparam int QW = $clog2(QD);

    logic [QW:0]   r_used;
    logic [31:0]   r_key [6];
    logic [1:0]    r_fn  [6];
    logic          h_valid;
    logic [IDX_W-1:0] h_idx1, h_idx2;
    t_job          r_q [QD];
    logic [QW-1:0] r_wp, r_rp;
    logic [QW:0]   r_cnt;
    logic          acc, push, pop;

    // in-flight plus queued must fit the queue
    assign o_ready = (r_used < (QW+1)'(QD));
    assign acc     = i_valid && o_ready;
    assign push    = h_valid;
    assign pop     = o_job_valid && i_job_ready;

    chs_hash u_hash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(acc), .i_key(i_data.key),
        .o_valid(h_valid), .o_idx1(h_idx1), .o_idx2(h_idx2)
    );

    // key and func ride alongside the hash pipe
    always_ff @(posedge i_clk) begin
        r_key[0] <= i_data.key;
        r_fn[0]  <= i_data.func;
        for (int k = 1; k < 6; k++) begin
            r_key[k] <= r_key[k-1];
            r_fn[k]  <= r_fn[k-1];
        end
    end

    // job queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_used <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt  <= r_cnt + (QW+1)'(push) - (QW+1)'(pop);
            r_used <= r_used + (QW+1)'(acc) - (QW+1)'(pop);
        end
    end
    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= '{func: r_fn[5], key: r_key[5], idx1: h_idx1, idx2: h_idx2};
    end

    assign o_job_valid = (r_cnt != '0);
    assign o_job       = r_q[r_rp];
endmodule

// ===== rtl/chs_back.sv =====
// back end: table access, eviction loop, result register
// depends on chs_pkg, chs_ram, chs_hash
module chs_back import chs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [KICK_W-1:0] i_max_kicks,
    input  logic              i_job_valid,
    output logic              o_job_ready,
    input  t_job              i_job,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_word         o_data
);
    typedef enum logic [7:0] {
        S_CLR   = 8'b00000001,
        S_IDLE  = 8'b00000010,
        S_READ  = 8'b00000100,
        S_DEC   = 8'b00001000,
        S_HASH  = 8'b00010000,
        S_PROBE = 8'b00100000,
        S_KICK  = 8'b01000000,
        S_OUT   = 8'b10000000
    } t_state;

    t_state r_st, n_st;
    logic [IDX_W-1:0] r_clr;
    logic [CNT_W-1:0] r_cnt;
    logic [KICK_W-1:0] r_ev;
    logic [31:0] r_cur, r_key;
    logic [1:0]  r_fn;
    logic [IDX_W-1:0] r_i1, r_i2, r_idx;
    logic r_t1;
    logic [3:0] r_wait;
    t_out_word r_res;

    // table word: valid bit over the key
    logic we1, we2;
    logic [IDX_W-1:0] a1, a2;
    logic [32:0] wd, rd1, rd2;
    logic h_valid;
    logic [IDX_W-1:0] h_i1, h_i2;
    logic in1, in2, occ;
    logic [32:0] rd_sel;
    logic del1, del2, place;

    chs_ram #(.WIDTH(33), .DEPTH(SLOTS)) u_t1 (
        .i_clk(i_clk), .i_we(we1), .i_addr(a1), .i_wdata(wd), .o_rdata(rd1));
    chs_ram #(.WIDTH(33), .DEPTH(SLOTS)) u_t2 (
        .i_clk(i_clk), .i_we(we2), .i_addr(a2), .i_wdata(wd), .o_rdata(rd2));

    // rehash of an evicted key
    chs_hash u_rehash (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_st == S_KICK), .i_key(r_cur),
        .o_valid(h_valid), .o_idx1(h_i1), .o_idx2(h_i2));

    assign in1 = rd1[32] && (rd1[31:0] == r_key);
    assign in2 = rd2[32] && (rd2[31:0] == r_key);
    assign rd_sel = r_t1 ? rd1 : rd2;
    assign occ = rd_sel[32];
    assign del1 = (r_st == S_DEC) && (r_fn == FUNC_DELETE) && in1;
    assign del2 = (r_st == S_DEC) && (r_fn == FUNC_DELETE) && !in1 && in2;
    assign place = (r_st == S_PROBE) && (r_wait == '0) && (!occ || r_ev < i_max_kicks);
    assign o_job_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_data  = r_res;

    // ram ports: clearing pass, slot reads, delete on decode, swap-write on probe
    always_comb begin
        a1 = (r_st == S_CLR) ? r_clr :
             (r_st == S_READ || r_st == S_DEC) ? r_i1 : r_idx;
        a2 = (r_st == S_CLR) ? r_clr :
             (r_st == S_READ || r_st == S_DEC) ? r_i2 : r_idx;
        wd = (r_st == S_CLR) ? '0 : {(r_st == S_PROBE), r_cur};
        we1 = (r_st == S_CLR) || del1 || (place && r_t1);
        we2 = (r_st == S_CLR) || del2 || (place && !r_t1);
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_CLR:   n_st = (r_clr == IDX_W'(SLOTS - 1)) ? S_IDLE : S_CLR;
            S_IDLE:  if (i_job_valid) n_st = S_READ;
            S_READ:  n_st = S_DEC;
            S_DEC:   n_st = (r_fn == FUNC_INSERT && !in1 && !in2) ? S_PROBE : S_OUT;
            S_HASH:  if (h_valid) n_st = S_PROBE;
            S_PROBE: n_st = (r_wait != '0) ? S_PROBE :
                            (!occ || r_ev >= i_max_kicks) ? S_OUT : S_KICK;
            S_KICK:  n_st = S_HASH;
            S_OUT:   if (i_ready) n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_cnt <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == S_CLR) r_clr <= r_clr + 1'b1;
            if (del1 || del2) r_cnt <= r_cnt - 1'b1;
            if (place && !occ) r_cnt <= r_cnt + 1'b1;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_IDLE: begin
                r_key <= i_job.key; r_fn <= i_job.func;
                r_i1 <= i_job.idx1; r_i2 <= i_job.idx2;
                r_cur <= i_job.key; r_ev <= '0; r_wait <= '0;
            end
            S_DEC: begin
                r_t1 <= 1'b1; r_idx <= r_i1; r_wait <= 4'd1;
                r_res.homeless_key <= '0;
                r_res.found <= (r_fn == FUNC_LOOKUP || r_fn == FUNC_DELETE) && (in1 || in2);
                if (r_fn == FUNC_INSERT)
                    r_res.status <= (in1 || in2) ? ST_PRESENT : ST_DONE;
                else if (r_fn == FUNC_LOOKUP || r_fn == FUNC_DELETE)
                    r_res.status <= (in1 || in2) ? ST_DONE : ST_MISS;
                else
                    r_res.status <= ST_MISS;
                r_res.entry_count <= (r_fn == FUNC_DELETE && (in1 || in2)) ?
                                     r_cnt - 1'b1 : r_cnt;
            end
            S_PROBE: begin
                if (r_wait != '0) begin
                    r_wait <= r_wait - 1'b1;
                end else if (!occ) begin
                    r_res.status <= ST_DONE;
                    r_res.entry_count <= r_cnt + 1'b1;
                end else if (r_ev >= i_max_kicks) begin
                    r_res.status <= ST_FULL;
                    r_res.homeless_key <= r_cur;
                    r_res.entry_count <= r_cnt;
                end else begin
                    r_cur <= rd_sel[31:0]; r_ev <= r_ev + 1'b1; r_t1 <= !r_t1;
                end
            end
            S_HASH: if (h_valid) begin
                r_idx <= r_t1 ? h_i1 : h_i2; r_wait <= 4'd1;
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/cuckoo_hash_set.sv =====
// top level of the cuckoo hash set
// depends on chs_pkg, chs_front, chs_back, cuckoo_hash_set_assert.svh
//
// channel  direction  handshake            word
// in       input      i_valid / o_ready    t_in_word (func, key)
// out      output     o_valid / i_ready    t_out_word
// cfg      input      i_cfg_we             max_kicks
//
// lookup, delete, duplicate insert, ignored func: result after the hash pipe, job queue, read and decode
// insert into a free slot also passes the probe state; each eviction adds kick, the rehash pipe and a probe
// synchronous active-low reset zeroes count, sets max_kicks=2048, then a
// clearing pass over all 1024 slots empties both tables while the front keeps queuing
// a held result stalls the back; the front takes up to 8 words, then drops o_ready
`include "cuckoo_hash_set_assert.svh"
module cuckoo_hash_set import chs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  t_in_word          i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output t_out_word         o_data,
    input  logic              i_cfg_we,
    input  logic [KICK_W-1:0] i_cfg_data
);
    logic [KICK_W-1:0] r_kicks;
    logic job_valid, job_ready;
    t_job job;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_kicks <= KICKS_RESET;
        else if (i_cfg_we) r_kicks <= i_cfg_data;
    end

    chs_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_job_valid(job_valid), .i_job_ready(job_ready), .o_job(job));

    chs_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_max_kicks(r_kicks),
        .i_job_valid(job_valid), .o_job_ready(job_ready), .i_job(job),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));

    // checks
    `CHS_ASSERT_IMPL(a_full_key, i_clk, i_rst_n, o_valid && o_data.status != ST_FULL, o_data.homeless_key == '0)
    `CHS_ASSERT_IMPL(a_found, i_clk, i_rst_n, o_valid && o_data.found, o_data.status == ST_DONE)
    `CHS_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
endmodule
